// File: rtl/json_string_unescape_decoder_defines.svh
// Assertion macros shared by the string unescape decoder modules.
`ifndef JSON_STRING_UNESCAPE_DECODER_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DECODER_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define JSUD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define JSUD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/jsud_pkg.sv
// Types and constants shared by the string unescape decoder modules.
`timescale 1ns / 1ps

package jsud_pkg;

    // One input beat: a text byte and the restart flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [2:0] error_code;
        logic       last;
    } out_t;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } phase_t;

    // Results produced by one text byte, first result in res[0].
    typedef struct packed {
        logic [1:0]     cnt;
        out_t [2:0]     res;
    } dec_t;

    // Result status codes.
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EOT_WAIT  = 3'd1;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd2;
    localparam logic [2:0] ERR_EOT_ESC   = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd5;
    localparam logic [2:0] ERR_EOT_STR   = 3'd6;

    // Characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    // Result queue size.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QCNT_W = 3;

endpackage

// File: rtl/jsud_decode.sv
// Phase tracking and per-byte decode of escapes and UTF-8 encoding.
`timescale 1ns / 1ps
`include "json_string_unescape_decoder_defines.svh"

module jsud_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  jsud_pkg::in_t  item,
    input  logic           step,
    output jsud_pkg::dec_t dec
);

    jsud_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       hex_count_reg, hex_count_next;
    logic [15:0]      code_point_reg, code_point_next;

    logic [7:0]  c;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] cp_new;

    assign c = item.in_byte;

    // Hex digit recognition; letters in either case map to 10 through 15.
    always_comb
    begin
        is_hex  = 1'b0;
        hex_val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            is_hex = 1'b1;
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            is_hex  = 1'b1;
            hex_val = c[3:0] + 4'd9;
        end
    end

    assign cp_new = {code_point_reg[11:0], hex_val};

    // Next state of phase, digit count and collected code point.
    always_comb
    begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        if (item.restart)
        begin
            phase_next      = jsud_pkg::PH_WAIT;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
        end
        else
        begin
            unique case (phase_reg)
                jsud_pkg::PH_STR:
                begin
                    if (c == jsud_pkg::CH_NUL || c == jsud_pkg::CH_QUOTE)
                    begin
                        phase_next      = jsud_pkg::PH_WAIT;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                    else if (c == jsud_pkg::CH_BSLASH)
                    begin
                        phase_next = jsud_pkg::PH_ESC;
                    end
                end
                jsud_pkg::PH_ESC:
                begin
                    unique case (c) inside
                        jsud_pkg::CH_QUOTE, jsud_pkg::CH_BSLASH, jsud_pkg::CH_SLASH,
                        jsud_pkg::CH_LC_B, jsud_pkg::CH_LC_F, jsud_pkg::CH_LC_N,
                        jsud_pkg::CH_LC_R, jsud_pkg::CH_LC_T:
                        begin
                            phase_next = jsud_pkg::PH_STR;
                        end
                        jsud_pkg::CH_LC_U:
                        begin
                            phase_next      = jsud_pkg::PH_HEX;
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                        end
                        default:
                        begin
                            phase_next      = jsud_pkg::PH_WAIT;
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                        end
                    endcase
                end
                jsud_pkg::PH_HEX:
                begin
                    if (!is_hex)
                    begin
                        phase_next      = jsud_pkg::PH_WAIT;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next  = hex_count_reg + 2'd1;
                        code_point_next = cp_new;
                    end
                    else
                    begin
                        phase_next      = jsud_pkg::PH_STR;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                end
                default:
                begin
                    // Waiting for the opening quote; whitespace keeps waiting.
                    if (c == jsud_pkg::CH_QUOTE)
                    begin
                        phase_next      = jsud_pkg::PH_STR;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                    else
                    begin
                        phase_next      = jsud_pkg::PH_WAIT;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                end
            endcase
        end
    end

    // Results caused by the current byte.
    always_comb
    begin
        logic err;
        logic [1:0] n;
        err = 1'b0;
        n   = 2'd0;
        dec = '0;
        if (!item.restart)
        begin
            unique case (phase_reg)
                jsud_pkg::PH_STR:
                begin
                    if (c == jsud_pkg::CH_NUL)
                    begin
                        err = 1'b1;
                        dec.res[0].error_code = jsud_pkg::ERR_EOT_STR;
                    end
                    else if (c == jsud_pkg::CH_QUOTE)
                    begin
                        n = 2'd1;
                        dec.res[0].status = jsud_pkg::ST_DONE;
                    end
                    else if (c != jsud_pkg::CH_BSLASH)
                    begin
                        n = 2'd1;
                        dec.res[0].out_byte = c;
                    end
                end
                jsud_pkg::PH_ESC:
                begin
                    unique case (c) inside
                        jsud_pkg::CH_NUL:
                        begin
                            err = 1'b1;
                            dec.res[0].error_code = jsud_pkg::ERR_EOT_ESC;
                        end
                        jsud_pkg::CH_QUOTE, jsud_pkg::CH_BSLASH, jsud_pkg::CH_SLASH:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = c;
                        end
                        jsud_pkg::CH_LC_B:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = jsud_pkg::CH_BS;
                        end
                        jsud_pkg::CH_LC_F:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = jsud_pkg::CH_FF;
                        end
                        jsud_pkg::CH_LC_N:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = jsud_pkg::CH_LF;
                        end
                        jsud_pkg::CH_LC_R:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = jsud_pkg::CH_CR;
                        end
                        jsud_pkg::CH_LC_T:
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = jsud_pkg::CH_TAB;
                        end
                        jsud_pkg::CH_LC_U:
                        begin
                            n = 2'd0;
                        end
                        default:
                        begin
                            err = 1'b1;
                            dec.res[0].error_code = jsud_pkg::ERR_BAD_ESC;
                        end
                    endcase
                end
                jsud_pkg::PH_HEX:
                begin
                    if (!is_hex)
                    begin
                        err = 1'b1;
                        dec.res[0].error_code = jsud_pkg::ERR_BAD_HEX;
                    end
                    else if (hex_count_reg == 2'd3)
                    begin
                        // Fourth digit: encode the code point as UTF-8.
                        if (cp_new[15:7] == 9'd0)
                        begin
                            n = 2'd1;
                            dec.res[0].out_byte = cp_new[7:0];
                        end
                        else if (cp_new[15:11] == 5'd0)
                        begin
                            n = 2'd2;
                            dec.res[0].out_byte = {3'b110, cp_new[10:6]};
                            dec.res[1].out_byte = {2'b10, cp_new[5:0]};
                        end
                        else
                        begin
                            n = 2'd3;
                            dec.res[0].out_byte = {4'b1110, cp_new[15:12]};
                            dec.res[1].out_byte = {2'b10, cp_new[11:6]};
                            dec.res[2].out_byte = {2'b10, cp_new[5:0]};
                        end
                    end
                end
                default:
                begin
                    if (c == jsud_pkg::CH_NUL)
                    begin
                        err = 1'b1;
                        dec.res[0].error_code = jsud_pkg::ERR_EOT_WAIT;
                    end
                    else if (c != jsud_pkg::CH_SPACE && c != jsud_pkg::CH_TAB &&
                             c != jsud_pkg::CH_CR && c != jsud_pkg::CH_LF &&
                             c != jsud_pkg::CH_QUOTE)
                    begin
                        err = 1'b1;
                        dec.res[0].error_code = jsud_pkg::ERR_NO_QUOTE;
                    end
                end
            endcase
        end
        // An error is a single result without the last flag.
        if (err)
        begin
            n = 2'd1;
            dec.res[0].status   = jsud_pkg::ST_ERR;
            dec.res[0].out_byte = 8'd0;
        end
        else if (n != 2'd0)
        begin
            dec.res[n - 2'd1].last = 1'b1;
        end
        dec.cnt = n;
    end

    // State registers advance once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= jsud_pkg::PH_WAIT;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

    `JSUD_ASSERT(a_open_quote, clk, rst_n, step && !item.restart && phase_reg == jsud_pkg::PH_WAIT && item.in_byte == jsud_pkg::CH_QUOTE |=> phase_reg == jsud_pkg::PH_STR, "opening quote did not enter the string")
    `JSUD_ASSERT(a_three_bytes, clk, rst_n, dec.cnt == 2'd3 |-> phase_reg == jsud_pkg::PH_HEX && hex_count_reg == 2'd3, "three results outside the final hex digit")

endmodule

// File: rtl/jsud_queue.sv
// Small result queue that takes up to three results at once and gives one per cycle while pop is high.
`timescale 1ns / 1ps

module jsud_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    input  jsud_pkg::dec_t              push,
    output logic                        push_ready,
    input  logic                        pop,
    output jsud_pkg::out_t              head,
    output logic [jsud_pkg::QCNT_W-1:0] cnt
);

    localparam int unsigned DEPTH = jsud_pkg::QDEPTH;
    localparam int unsigned CW    = jsud_pkg::QCNT_W;

    jsud_pkg::out_t slot_reg  [DEPTH];
    jsud_pkg::out_t slot_next [DEPTH];
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  cnt_after_pop;
    logic [CW-1:0]  push_cnt;
    logic           do_push;

    assign cnt_after_pop = cnt_reg - {{(CW-1){1'b0}}, pop};
    assign push_cnt      = {{(CW-2){1'b0}}, push.cnt};
    assign push_ready    = ({1'b0, cnt_after_pop} + {1'b0, push_cnt}) <= (CW+1)'(DEPTH);
    assign do_push       = push_valid && push_ready;
    assign head          = slot_reg[0];
    assign cnt           = cnt_reg;

    // Shift down on a pop, then append new results after the survivors.
    always_comb
    begin
        logic [CW-1:0] offs;
        offs = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            offs = CW'(i) - cnt_after_pop;
            if (do_push && CW'(i) >= cnt_after_pop && offs < push_cnt)
            begin
                slot_next[i] = push.res[offs[1:0]];
            end
        end
        cnt_next = do_push ? cnt_after_pop + push_cnt : cnt_after_pop;
    end

    // Count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Result slots carry payload only.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

// File: rtl/json_string_unescape_decoder.sv
// Top level of the JSON string unescape decoder with UTF-8 output.
//
//   Channel  Signals                                Beat
//   byte     byte_valid, byte_stall, byte_data      one text byte and restart flag
//   result   result_valid, result_stall, result_data one decoded byte or status
//
// A byte is registered on acceptance and decoded in the next cycle into up to three results.
// Throughput is one byte per cycle; the four-entry result queue is the only limit.
// A final \u digit that yields three UTF-8 bytes can hold the input until the result queue has room for them.
// A byte's first result passes through the input register and a result queue slot before it reaches the output.
// Asynchronous active-low reset empties the input register and result queue.
`timescale 1ns / 1ps
`include "json_string_unescape_decoder_defines.svh"

module json_string_unescape_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  jsud_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_stall,
    output jsud_pkg::out_t result_data
);

    logic                        in_valid_reg, in_valid_next;
    jsud_pkg::in_t               in_reg;
    logic                        push_ready;
    logic                        consume;
    logic                        accept;
    logic                        pop;
    logic [jsud_pkg::QCNT_W-1:0] q_cnt;
    jsud_pkg::dec_t              dec;

    // Input register handshake.
    assign consume       = in_valid_reg && push_ready;
    assign byte_stall    = in_valid_reg && !push_ready;
    assign accept        = byte_valid && !byte_stall;
    assign in_valid_next = accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= byte_data;
        end
    end

    // Decode of the registered byte.
    jsud_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_reg),
        .step  (consume),
        .dec   (dec)
    );

    // Result queue drives the output channel.
    assign result_valid = (q_cnt != '0);
    assign pop          = result_valid && !result_stall;

    jsud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid_reg),
        .push       (dec),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (result_data),
        .cnt        (q_cnt)
    );

    `JSUD_ASSERT(a_hold_needs_backlog, clk, rst_n, in_valid_reg && !push_ready |-> q_cnt >= 3'd2, "input held with room in the result queue")
    `JSUD_ASSERT(a_err_not_last, clk, rst_n, result_valid && result_data.status == jsud_pkg::ST_ERR |-> !result_data.last && result_data.out_byte == 8'd0, "error beat carries last or data")
    `JSUD_ASSERT_ALWAYS(a_queue_bound, clk, q_cnt <= 3'd4, "result queue count beyond its depth")

endmodule

// File: tb/json_string_unescape_decoder_tb.sv
// Self-checking testbench for the JSON string unescape decoder with UTF-8 output.
`timescale 1ns / 1ps

module json_string_unescape_decoder_tb;
    import jsud_pkg::*;

    // Tracks the decoder state and holds the result beats still owed by the block.
    class unescape_scoreboard;
        phase_t      phase;
        logic [1:0]  hex_cnt;
        logic [15:0] code_pt;
        out_t        expected_out[$];
        int          fail_count;
        int          beats_checked;
        int          strings_done;
        int          errors_seen;

        function new();
            go_idle();
            fail_count    = 0;
            beats_checked = 0;
            strings_done  = 0;
            errors_seen   = 0;
        endfunction

        // Back to waiting for an opening quote with the escape state cleared.
        function void go_idle();
            phase   = PH_WAIT;
            hex_cnt = 2'd0;
            code_pt = 16'd0;
        endfunction

        function out_t beat(logic [7:0] d, logic [1:0] st, logic [2:0] err);
            out_t r;
            r.out_byte   = d;
            r.status     = st;
            r.error_code = err;
            r.last       = 1'b0;
            return r;
        endfunction

        // Decodes one accepted text beat and queues the result beats it causes.
        function void note_byte(in_t b);
            out_t        res[3];
            int          n;
            int          nib;
            logic [7:0]  c;
            logic [15:0] cp;
            n = 0;
            c = b.in_byte;
            if (b.restart)
            begin
                go_idle();
                return;
            end
            case (phase)
                PH_STR:
                begin
                    if (c == CH_NUL)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_EOT_STR);
                        n = 1;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_DONE, ERR_NONE);
                        n = 1;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        phase = PH_ESC;
                    end
                    else
                    begin
                        res[0] = beat(c, ST_DATA, ERR_NONE);
                        n = 1;
                    end
                end
                PH_ESC:
                begin
                    if (c == CH_NUL)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_EOT_ESC);
                        n = 1;
                    end
                    else if (c == CH_LC_U)
                    begin
                        phase   = PH_HEX;
                        hex_cnt = 2'd0;
                        code_pt = 16'd0;
                    end
                    else if (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH})
                    begin
                        phase  = PH_STR;
                        res[0] = beat(c, ST_DATA, ERR_NONE);
                        n = 1;
                    end
                    else if (c inside {CH_LC_B, CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T})
                    begin
                        phase = PH_STR;
                        case (c)
                            CH_LC_B: res[0] = beat(CH_BS, ST_DATA, ERR_NONE);
                            CH_LC_F: res[0] = beat(CH_FF, ST_DATA, ERR_NONE);
                            CH_LC_N: res[0] = beat(CH_LF, ST_DATA, ERR_NONE);
                            CH_LC_R: res[0] = beat(CH_CR, ST_DATA, ERR_NONE);
                            default: res[0] = beat(CH_TAB, ST_DATA, ERR_NONE);
                        endcase
                        n = 1;
                    end
                    else
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_BAD_ESC);
                        n = 1;
                    end
                end
                PH_HEX:
                begin
                    nib = -1;
                    if (c >= "0" && c <= "9") nib = c - "0";
                    else if (c >= "a" && c <= "f") nib = c - "a" + 10;
                    else if (c >= "A" && c <= "F") nib = c - "A" + 10;
                    if (nib < 0)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_BAD_HEX);
                        n = 1;
                    end
                    else
                    begin
                        cp = {code_pt[11:0], 4'(nib)};
                        if (hex_cnt < 2'd3)
                        begin
                            code_pt = cp;
                            hex_cnt = hex_cnt + 2'd1;
                        end
                        else
                        begin
                            // Fourth digit: emit the code point as UTF-8.
                            phase   = PH_STR;
                            hex_cnt = 2'd0;
                            code_pt = 16'd0;
                            if (cp < 16'h0080)
                            begin
                                res[0] = beat(cp[7:0], ST_DATA, ERR_NONE);
                                n = 1;
                            end
                            else if (cp < 16'h0800)
                            begin
                                res[0] = beat({3'b110, cp[10:6]}, ST_DATA, ERR_NONE);
                                res[1] = beat({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
                                n = 2;
                            end
                            else
                            begin
                                res[0] = beat({4'b1110, cp[15:12]}, ST_DATA, ERR_NONE);
                                res[1] = beat({2'b10, cp[11:6]}, ST_DATA, ERR_NONE);
                                res[2] = beat({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
                                n = 3;
                            end
                        end
                    end
                end
                default:
                begin
                    if (c == CH_NUL)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_EOT_WAIT);
                        n = 1;
                    end
                    else if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
                    begin
                        // Whitespace before the string is skipped.
                    end
                    else if (c != CH_QUOTE)
                    begin
                        go_idle();
                        res[0] = beat(8'h00, ST_ERR, ERR_NO_QUOTE);
                        n = 1;
                    end
                    else
                    begin
                        phase   = PH_STR;
                        hex_cnt = 2'd0;
                        code_pt = 16'd0;
                    end
                end
            endcase
            // An error beat stands alone and never carries the last flag.
            if (n > 0 && res[0].status != ST_ERR) res[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_out.push_back(res[i]);
        endfunction

        // Compares one accepted result beat with the oldest owed beat.
        function void check_result(out_t got);
            out_t want;
            if (expected_out.size() == 0)
            begin
                $display("%0t: unexpected result beat byte=%02h status=%0d err=%0d last=%0b",
                         $time, got.out_byte, got.status, got.error_code, got.last);
                fail_count++;
                return;
            end
            want = expected_out.pop_front();
            beats_checked++;
            if (got.out_byte !== want.out_byte || got.status !== want.status ||
                got.error_code !== want.error_code || got.last !== want.last)
            begin
                $display("%0t: mismatch expected byte=%02h status=%0d err=%0d last=%0b, %s",
                         $time, want.out_byte, want.status, want.error_code, want.last,
                         $sformatf("got byte=%02h status=%0d err=%0d last=%0b",
                                   got.out_byte, got.status, got.error_code, got.last));
                fail_count++;
            end
            else if (want.status == ST_DONE)
            begin
                strings_done++;
            end
            else if (want.status == ST_ERR)
            begin
                errors_seen++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic byte_valid;
    logic byte_stall;
    in_t  byte_data;
    logic result_valid;
    logic result_stall;
    out_t result_data;

    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_left;
    int items_sent;

    unescape_scoreboard sb;

    json_string_unescape_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #2 clk = ~clk;

    // Offers one text beat after a random idle gap and waits until it is taken.
    task automatic send_byte(input logic [7:0] value, input logic rst_flag);
        in_t b;
        b.in_byte = value;
        b.restart = rst_flag;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            @(negedge clk);
            byte_valid = 1'b0;
        end
        @(negedge clk);
        byte_valid = 1'b1;
        byte_data  = b;
        do @(posedge clk); while (byte_stall);
        sb.note_byte(b);
        if (!rst_flag) items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Drops valid and waits until every owed result beat has arrived.
    task automatic wait_drain();
        @(negedge clk);
        byte_valid = 1'b0;
        while (sb.expected_out.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return "0" + {4'd0, nib};
        return ($urandom_range(0, 1) ? "A" : "a") + {4'd0, nib} - 8'd10;
    endfunction

    // One string, mostly well formed, sometimes cut short by an error or a restart.
    task automatic send_random_string();
        int          n_elem;
        int          kind;
        int          good;
        logic [7:0]  c;
        logic [15:0] cp;
        repeat ($urandom_range(0, 2)) send_byte(blank_char(), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        n_elem = $urandom_range(0, 8);
        for (int k = 0; k < n_elem; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
                send_byte(c, 1'b0);
            end
            else if (kind < 7)
            begin
                send_byte(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0:       send_byte(CH_QUOTE, 1'b0);
                    1:       send_byte(CH_BSLASH, 1'b0);
                    2:       send_byte(CH_SLASH, 1'b0);
                    3:       send_byte(CH_LC_B, 1'b0);
                    4:       send_byte(CH_LC_F, 1'b0);
                    5:       send_byte(CH_LC_N, 1'b0);
                    6:       send_byte(CH_LC_R, 1'b0);
                    default: send_byte(CH_LC_T, 1'b0);
                endcase
            end
            else
            begin
                // Unicode escape spread over the one, two and three byte encodings.
                case ($urandom_range(0, 5))
                    0: cp = 16'($urandom_range(0, 16'h007f));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                    2: cp = 16'($urandom_range(16'h0800, 16'hffff));
                    3: cp = 16'($urandom_range(16'hd800, 16'hdfff));
                    4:
                    begin
                        case ($urandom_range(0, 5))
                            0:       cp = 16'h0000;
                            1:       cp = 16'h007f;
                            2:       cp = 16'h0080;
                            3:       cp = 16'h07ff;
                            4:       cp = 16'h0800;
                            default: cp = 16'hffff;
                        endcase
                    end
                    default: cp = 16'($urandom);
                endcase
                send_byte(CH_BSLASH, 1'b0);
                send_byte(CH_LC_U, 1'b0);
                for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]), 1'b0);
            end
        end
        // Closing quote most of the time, otherwise one of the ways a string breaks.
        case ($urandom_range(0, 19))
            14: send_byte(CH_NUL, 1'b0);
            15:
            begin
                send_byte(CH_BSLASH, 1'b0);
                do c = 8'($urandom_range(1, 255));
                while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F,
                                 CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_U});
                send_byte(c, 1'b0);
            end
            16:
            begin
                send_byte(CH_BSLASH, 1'b0);
                send_byte(CH_NUL, 1'b0);
            end
            17:
            begin
                send_byte(CH_BSLASH, 1'b0);
                send_byte(CH_LC_U, 1'b0);
                good = $urandom_range(0, 3);
                repeat (good) send_byte(hex_char(4'($urandom)), 1'b0);
                if ($urandom_range(0, 3) == 0) c = CH_NUL;
                else do c = 8'($urandom); while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
                send_byte(c, 1'b0);
            end
            18: send_byte(8'($urandom), 1'b1);
            default: send_byte(CH_QUOTE, 1'b0);
        endcase
    endtask

    // Stray bytes outside a string, with the odd restart and end of text.
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0:       send_byte(CH_NUL, 1'b0);
                1:       send_byte(blank_char(), 1'b0);
                2:       send_byte(8'($urandom), 1'b1);
                default: send_byte(8'($urandom), 1'b0);
            endcase
        end
    endtask

    task automatic run_profile(input int idle_pct, input int stall_pct, input int quota);
        int goal;
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_string();
        end
        wait_drain();
    endtask

    // Result side: sample on the rising edge, choose the next stall on the falling edge.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall) sb.check_result(result_data);
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall = ($urandom_range(0, 99) < rcv_stall_pct);
            end
        end
    end

    // Main sequence: reset, directed cases, random profiles, then the long hold-off.
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        byte_data     = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_left     = 0;
        items_sent    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Whitespace skip, byte extremes, a simple escape, NUL and surrogate escapes.
        send_text(" \t\"");
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_text("\\n\\u0000\\ud83D");
        // Restart in mid-string, then every error kind.
        send_byte("x", 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_text("x");
        send_text("\"\\");
        send_byte(CH_NUL, 1'b0);
        send_text("\"\\u");
        send_byte(CH_NUL, 1'b0);
        send_text("\"\\q");
        send_text("\"");
        send_byte(CH_NUL, 1'b0);
        send_text("\r\n\"\"");
        wait_drain();

        run_profile(0, 0, 65);
        run_profile(83, 0, 65);
        run_profile(0, 83, 65);
        run_profile(20, 20, 65);

        // Output held off long enough for the result queue to fill and stall the input.
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_left     = 60;
        send_text("\"fill\\u20ACup\\u00e9\\uFFFFqueue\"");
        wait_drain();

        repeat (10) @(posedge clk);
        $display("Sent %0d text beats through four idle profiles and a long output hold-off.",
                 items_sent);
        $display("Checked %0d result beats: %0d strings closed, %0d errors reported.",
                 sb.beats_checked, sb.strings_done, sb.errors_seen);
        if (sb.fail_count == 0 && sb.expected_out.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
